// ===== hw/rtl/buddy_page_allocator_core_macros.svh =====
// Assertion macros shared by the buddy page allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH

// Checks a condition at every clock edge outside of reset.
`define BPA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define BPA_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/bpa_pkg.sv =====
// Types and constants of the buddy page allocator.
package bpa_pkg;

    localparam int unsigned POOL_PAGES = 1024;
    localparam int unsigned TREE_NODES = 2 * POOL_PAGES - 1;
    localparam int unsigned NODE_W     = $clog2(TREE_NODES);
    localparam int unsigned PAGE_W     = $clog2(POOL_PAGES);
    localparam int unsigned SIZE_W     = $clog2(POOL_PAGES + 1);

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [SIZE_W-1:0] bpa_size_t;
    typedef logic [16:0]       req_t;

    typedef logic [1:0]  func_field_t;
    typedef logic [15:0] pages16_t;
    typedef logic [1:0]  status_field_t;
    typedef logic [9:0]  off_field_t;
    typedef logic [10:0] count_field_t;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_QUERY = 2'd2
    } bpa_func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTALLOC = 2'd3
    } bpa_status_t;

endpackage

// ===== hw/rtl/bpa_if.sv =====
// Request and response channel interfaces of the buddy page allocator.
interface bpa_req_if;
    logic                     valid;
    logic                     ready;
    bpa_pkg::func_field_t     func;
    bpa_pkg::pages16_t        request_pages;
    bpa_pkg::pages16_t        page_offset;

    modport source (output valid, output func, output request_pages, output page_offset,
                    input ready);
    modport sink (input valid, input func, input request_pages, input page_offset,
                  output ready);
endinterface

interface bpa_rsp_if;
    logic                     valid;
    logic                     ready;
    bpa_pkg::status_field_t   status;
    bpa_pkg::off_field_t      granted_offset;
    bpa_pkg::count_field_t    block_pages;
    bpa_pkg::count_field_t    pages_free;

    modport source (output valid, output status, output granted_offset, output block_pages,
                    output pages_free, input ready);
    modport sink (input valid, input status, input granted_offset, input block_pages,
                  input pages_free, output ready);
endinterface

// ===== hw/rtl/buddy_page_allocator_core.sv =====
// An allocate checks the root, descends one level per state to a block of the rounded size,
// marks it and climbs to the root updating each parent. Free and query climb from the leaf,
// one level per state, to the allocated block; a free then clears it and climbs to the root.
// One operation runs at a time, set by the single read port of the tree memory.
// After reset an init sweep writes all 2*POOL_PAGES-1 tree nodes, one per cycle; no request
// transaction is accepted until it completes.
`include "buddy_page_allocator_core_macros.svh"

module buddy_page_allocator_core (
    input  logic          clk,
    input  logic          rst_n,
    bpa_req_if.sink       req,
    bpa_rsp_if.source     rsp
);

    // The tree memory holds, for every node, the largest free block in its subtree.
    // Node 0 is the root, the children of node i are 2i+1 and 2i+2, and a zero marks
    // a node whose whole block is allocated. Each state of the walk consumes the read
    // data of the previous cycle and issues the next read.

    localparam bpa_pkg::node_t NODE_LAST = bpa_pkg::node_t'(bpa_pkg::TREE_NODES - 1);
    localparam bpa_pkg::node_t LEAF_BASE = bpa_pkg::node_t'(bpa_pkg::POOL_PAGES - 1);
    localparam bpa_pkg::bpa_size_t POOL_SIZE = bpa_pkg::bpa_size_t'(bpa_pkg::POOL_PAGES);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_A_ROOT,
        S_A_DESC,
        S_A_MARK,
        S_F_CHK,
        S_UP,
        S_DONE
    } state_t;

    // Tree memory with a registered read port.
    bpa_pkg::bpa_size_t tree_mem [bpa_pkg::TREE_NODES];
    bpa_pkg::bpa_size_t rd_data_reg;
    logic               rd_en;
    bpa_pkg::node_t     rd_addr;
    logic               wr_en;
    bpa_pkg::node_t     wr_addr;
    bpa_pkg::bpa_size_t wr_data;

    state_t              state_reg, state_next;
    bpa_pkg::bpa_func_t  func_reg, func_next;
    bpa_pkg::req_t       req_reg, req_next;
    bpa_pkg::node_t      idx_reg, idx_next;
    bpa_pkg::bpa_size_t  sz_reg, sz_next;
    bpa_pkg::page_t      off_reg, off_next;
    bpa_pkg::bpa_size_t  cur_reg, cur_next;
    bpa_pkg::bpa_size_t  free_cnt_reg, free_cnt_next;
    bpa_pkg::node_t      init_idx_reg, init_idx_next;
    bpa_pkg::bpa_size_t  init_sz_reg, init_sz_next;
    bpa_pkg::bpa_status_t res_status_reg, res_status_next;
    bpa_pkg::page_t      res_off_reg, res_off_next;
    bpa_pkg::bpa_size_t  res_blk_reg, res_blk_next;
    logic                out_valid_reg, out_valid_next;
    bpa_pkg::bpa_status_t out_status_reg, out_status_next;
    bpa_pkg::page_t      out_off_reg, out_off_next;
    bpa_pkg::bpa_size_t  out_blk_reg, out_blk_next;
    bpa_pkg::bpa_size_t  out_free_reg, out_free_next;

    // Rounds a request up to a power of two, with zero taken as one.
    function automatic bpa_pkg::req_t round_pow2(input bpa_pkg::pages16_t n);
        bpa_pkg::pages16_t x;
        begin
            x = n - 16'd1;
            x = x | (x >> 1);
            x = x | (x >> 2);
            x = x | (x >> 4);
            x = x | (x >> 8);
            if (n == 16'd0)
            begin
                return bpa_pkg::req_t'(1);
            end
            return bpa_pkg::req_t'({1'b0, x}) + bpa_pkg::req_t'(1);
        end
    endfunction

    function automatic bpa_pkg::node_t left_of(input bpa_pkg::node_t i);
        return bpa_pkg::node_t'({i, 1'b1});
    endfunction

    function automatic bpa_pkg::node_t parent_of(input bpa_pkg::node_t i);
        return (i - bpa_pkg::node_t'(1)) >> 1;
    endfunction

    function automatic bpa_pkg::node_t sibling_of(input bpa_pkg::node_t i);
        return i[0] ? i + bpa_pkg::node_t'(1) : i - bpa_pkg::node_t'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tree_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= tree_mem[rd_addr];
        end
    end

    // Walk datapath values shared by several states.
    logic [bpa_pkg::NODE_W:0] init_nxt;
    logic [bpa_pkg::NODE_W:0] init_nxt2;
    bpa_pkg::req_t      rd_ext;
    bpa_pkg::bpa_size_t half_sz;
    logic               go_left;
    bpa_pkg::node_t     desc_idx;
    bpa_pkg::node_t     up_parent;
    bpa_pkg::bpa_size_t up_psz;
    logic [bpa_pkg::SIZE_W:0] up_sum;
    bpa_pkg::bpa_size_t up_max;
    bpa_pkg::bpa_size_t up_val;
    bpa_pkg::node_t     leaf_idx;
    logic               off_bad;

    always_comb
    begin
        init_nxt  = {1'b0, init_idx_reg} + 1'b1;
        init_nxt2 = init_nxt + 1'b1;
        rd_ext    = bpa_pkg::req_t'(rd_data_reg);
        half_sz   = sz_reg >> 1;
        go_left   = rd_ext >= req_reg;
        desc_idx  = go_left ? left_of(idx_reg) : left_of(idx_reg) + bpa_pkg::node_t'(1);
        up_parent = parent_of(idx_reg);
        up_psz    = bpa_pkg::bpa_size_t'({sz_reg, 1'b0});
        up_sum    = {1'b0, cur_reg} + {1'b0, rd_data_reg};
        up_max    = (cur_reg > rd_data_reg) ? cur_reg : rd_data_reg;
        // Freeing merges two whole buddies back into their parent block.
        up_val    = ((func_reg == bpa_pkg::FN_FREE) && (up_sum == {1'b0, up_psz})) ?
                    up_psz : up_max;
        leaf_idx  = bpa_pkg::node_t'(req.page_offset) + LEAF_BASE;
        off_bad   = 32'(req.page_offset) >= bpa_pkg::POOL_PAGES;
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        sz_next         = sz_reg;
        off_next        = off_reg;
        cur_next        = cur_reg;
        free_cnt_next   = free_cnt_reg;
        init_idx_next   = init_idx_reg;
        init_sz_next    = init_sz_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_blk_next    = res_blk_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_off_next    = out_off_reg;
        out_blk_next    = out_blk_reg;
        out_free_next   = out_free_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                // Each node starts with the block size of its level.
                wr_en         = 1'b1;
                wr_addr       = init_idx_reg;
                wr_data       = init_sz_reg;
                init_idx_next = init_nxt[bpa_pkg::NODE_W-1:0];
                if ((init_nxt2 & init_nxt) == '0)
                begin
                    init_sz_next = init_sz_reg >> 1;
                end
                if (init_idx_reg == NODE_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next       = bpa_pkg::bpa_func_t'(req.func);
                    req_next        = round_pow2(req.request_pages);
                    res_status_next = bpa_pkg::ST_OK;
                    res_off_next    = '0;
                    res_blk_next    = '0;
                    unique case (req.func)
                        bpa_pkg::FN_ALLOC:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_A_ROOT;
                        end
                        bpa_pkg::FN_FREE, bpa_pkg::FN_QUERY:
                        begin
                            if (off_bad)
                            begin
                                res_status_next = bpa_pkg::ST_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                idx_next   = leaf_idx;
                                sz_next    = bpa_pkg::bpa_size_t'(1);
                                rd_en      = 1'b1;
                                rd_addr    = leaf_idx;
                                state_next = S_F_CHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_A_ROOT:
            begin
                if (rd_ext < req_reg)
                begin
                    res_status_next = bpa_pkg::ST_NOSPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = '0;
                    sz_next  = POOL_SIZE;
                    off_next = '0;
                    if (req_reg == bpa_pkg::req_t'(POOL_SIZE))
                    begin
                        state_next = S_A_MARK;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = left_of('0);
                        state_next = S_A_DESC;
                    end
                end
            end

            S_A_DESC:
            begin
                // The read data is the left child; take it if it is big enough.
                idx_next = desc_idx;
                sz_next  = half_sz;
                if (!go_left)
                begin
                    off_next = off_reg + bpa_pkg::page_t'(half_sz);
                end
                if (bpa_pkg::req_t'(half_sz) == req_reg)
                begin
                    state_next = S_A_MARK;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = left_of(desc_idx);
                end
            end

            S_A_MARK:
            begin
                wr_en         = 1'b1;
                wr_addr       = idx_reg;
                wr_data       = '0;
                cur_next      = '0;
                free_cnt_next = free_cnt_reg - bpa_pkg::bpa_size_t'(req_reg);
                res_off_next  = off_reg;
                res_blk_next  = sz_reg;
                if (idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = sibling_of(idx_reg);
                    state_next = S_UP;
                end
            end

            S_F_CHK:
            begin
                if (rd_data_reg == '0)
                begin
                    res_blk_next = sz_reg;
                    if (func_reg == bpa_pkg::FN_QUERY)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = idx_reg;
                        wr_data       = sz_reg;
                        cur_next      = sz_reg;
                        free_cnt_next = free_cnt_reg + sz_reg;
                        if (idx_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = sibling_of(idx_reg);
                            state_next = S_UP;
                        end
                    end
                end
                else if (idx_reg == '0)
                begin
                    res_status_next = bpa_pkg::ST_NOTALLOC;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = up_parent;
                    sz_next  = up_psz;
                    rd_en    = 1'b1;
                    rd_addr  = up_parent;
                end
            end

            S_UP:
            begin
                // The read data is the sibling of the node written last.
                wr_en    = 1'b1;
                wr_addr  = up_parent;
                wr_data  = up_val;
                cur_next = up_val;
                idx_next = up_parent;
                sz_next  = up_psz;
                if (up_parent == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = sibling_of(up_parent);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_off_next    = res_off_reg;
                    out_blk_next    = res_blk_reg;
                    out_free_next   = free_cnt_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            func_reg       <= bpa_pkg::FN_ALLOC;
            req_reg        <= '0;
            idx_reg        <= '0;
            sz_reg         <= '0;
            off_reg        <= '0;
            cur_reg        <= '0;
            free_cnt_reg   <= POOL_SIZE;
            init_idx_reg   <= '0;
            init_sz_reg    <= POOL_SIZE;
            res_status_reg <= bpa_pkg::ST_OK;
            res_off_reg    <= '0;
            res_blk_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= bpa_pkg::ST_OK;
            out_off_reg    <= '0;
            out_blk_reg    <= '0;
            out_free_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            req_reg        <= req_next;
            idx_reg        <= idx_next;
            sz_reg         <= sz_next;
            off_reg        <= off_next;
            cur_reg        <= cur_next;
            free_cnt_reg   <= free_cnt_next;
            init_idx_reg   <= init_idx_next;
            init_sz_reg    <= init_sz_next;
            res_status_reg <= res_status_next;
            res_off_reg    <= res_off_next;
            res_blk_reg    <= res_blk_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_off_reg    <= out_off_next;
            out_blk_reg    <= out_blk_next;
            out_free_reg   <= out_free_next;
        end
    end

    // A new request transaction is taken only between operations; the output register
    // lets it be taken while the previous response transaction still waits.
    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = bpa_pkg::status_field_t'(out_status_reg);
    assign rsp.granted_offset = bpa_pkg::off_field_t'(out_off_reg);
    assign rsp.block_pages    = bpa_pkg::count_field_t'(out_blk_reg);
    assign rsp.pages_free     = bpa_pkg::count_field_t'(out_free_reg);

    `BPA_ASSERT_ALWAYS(a_free_cnt_bound, free_cnt_reg <= POOL_SIZE, "free count above pool size")
    `BPA_ASSERT_ALWAYS(a_no_rw_collide, !(rd_en && wr_en && (rd_addr == wr_addr)),
                       "read and write hit one node")
    `BPA_ASSERT_ALWAYS(a_up_not_root, (state_reg != S_UP) || (idx_reg != '0),
                       "climb past the root")
    `BPA_ASSERT_NEXT(a_alloc_count, state_reg == S_A_MARK,
                     free_cnt_reg == $past(free_cnt_reg) - bpa_pkg::bpa_size_t'($past(req_reg)),
                     "free count not reduced by grant")

endmodule
